FILE: src/tlnef_pkg.sv
package tlnef_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Decimal places kept for the line number (count saturates below 10^10)
    localparam int DEC_DIGITS = 10;
    localparam int PAD_WIDTH  = 6;
    // Longest expansion of one byte: "M-^X$"
    localparam int TAIL_MAX   = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ENDS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARET_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CARET_NONPRINTING = 3'd4;

    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [6:0] CH_DEL7   = 7'h7F;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;
    localparam logic [3:0] BCD_NINE  = 4'd9;

    // One classified input byte, ready for expansion
    typedef struct packed {
        logic                                has_num;
        logic [DEC_DIGITS-1:0][3:0]          bcd;
        logic [TAIL_MAX-1:0][7:0]            tail;
        logic [2:0]                          tail_len;
    } job_t;

endpackage

FILE: src/tlnef_front.sv
module tlnef_front #(
    parameter int COUNT_WIDTH = tlnef_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             in_valid,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    input  logic                             q_full,
    output logic                             in_ready,
    output logic                             q_push,
    output tlnef_pkg::job_t                  q_job
);

    localparam logic [63:0] LIMIT64 = (COUNT_WIDTH >= 34) ? 64'd9999999999 :
                                      ((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] LIMIT = LIMIT64[COUNT_WIDTH-1:0];

    logic [1:0] number_mode_reg;
    logic       mark_ends_reg;
    logic       squeeze_reg;
    logic       caret_tabs_reg;
    logic       caret_np_reg;

    logic                   line_start_reg, line_start_next;
    logic                   blank_seen_reg, blank_seen_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [tlnef_pkg::DEC_DIGITS-1:0][3:0] bcd_reg, bcd_next, bcd_inc;

    logic       accept;
    logic       blank;
    logic       drop;
    logic       num;
    logic [6:0] low7;
    logic [tlnef_pkg::TAIL_MAX-1:0][7:0] tail;
    logic [2:0] tlen;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg <= tlnef_pkg::NUM_NONE;
            mark_ends_reg   <= 1'b0;
            squeeze_reg     <= 1'b0;
            caret_tabs_reg  <= 1'b0;
            caret_np_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlnef_pkg::CFG_NUMBER_MODE:       number_mode_reg <= cfg_wdata[1:0];
                tlnef_pkg::CFG_MARK_ENDS:         mark_ends_reg   <= cfg_wdata[0];
                tlnef_pkg::CFG_SQUEEZE_BLANKS:    squeeze_reg     <= cfg_wdata[0];
                tlnef_pkg::CFG_CARET_TABS:        caret_tabs_reg  <= cfg_wdata[0];
                tlnef_pkg::CFG_CARET_NONPRINTING: caret_np_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Decimal increment: a digit steps when every digit below it is nine
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < tlnef_pkg::DEC_DIGITS; i++)
        begin
            if (carry)
                bcd_inc[i] = (bcd_reg[i] == tlnef_pkg::BCD_NINE) ? 4'd0 : bcd_reg[i] + 4'd1;
            else
                bcd_inc[i] = bcd_reg[i];
            carry = carry && (bcd_reg[i] == tlnef_pkg::BCD_NINE);
        end
    end

    always_comb
    begin
        blank           = (in_byte == tlnef_pkg::CH_LF);
        drop            = 1'b0;
        num             = 1'b0;
        line_start_next = line_start_reg;
        blank_seen_next = blank_seen_reg;
        count_next      = count_reg;
        bcd_next        = bcd_reg;
        tail            = '0;
        tlen            = 3'd0;
        low7            = in_byte[6:0];

        if (line_start_reg)
        begin
            if (squeeze_reg)
            begin
                if (blank)
                begin
                    if (blank_seen_reg)
                        drop = 1'b1;
                    else
                        blank_seen_next = 1'b1;
                end
                else
                    blank_seen_next = 1'b0;
            end
            if (!drop)
            begin
                num = (number_mode_reg == tlnef_pkg::NUM_ALL) ||
                      ((number_mode_reg == tlnef_pkg::NUM_NONBLANK) && !blank);
                if (num && (count_reg != LIMIT))
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                    bcd_next   = bcd_inc;
                end
                line_start_next = 1'b0;
            end
        end

        if (!drop)
        begin
            if (blank)
            begin
                if (mark_ends_reg)
                begin
                    tail[tlen] = tlnef_pkg::CH_DOLLAR;
                    tlen = tlen + 3'd1;
                end
                tail[tlen] = tlnef_pkg::CH_LF;
                tlen = tlen + 3'd1;
                line_start_next = 1'b1;
            end
            else
            begin
                if (in_byte == tlnef_pkg::CH_TAB && caret_tabs_reg)
                begin
                    tail[0] = tlnef_pkg::CH_CARET;
                    tail[1] = tlnef_pkg::CH_I;
                    tlen = 3'd2;
                end
                else if (in_byte == tlnef_pkg::CH_TAB || !caret_np_reg)
                begin
                    tail[0] = in_byte;
                    tlen = 3'd1;
                end
                else
                begin
                    if (in_byte[7])
                    begin
                        tail[0] = tlnef_pkg::CH_M;
                        tail[1] = tlnef_pkg::CH_DASH;
                        tlen = 3'd2;
                    end
                    if (low7[6:5] == 2'b00)
                    begin
                        tail[tlen] = tlnef_pkg::CH_CARET;
                        tlen = tlen + 3'd1;
                        tail[tlen] = {3'b010, low7[4:0]};
                        tlen = tlen + 3'd1;
                    end
                    else if (low7 == tlnef_pkg::CH_DEL7)
                    begin
                        tail[tlen] = tlnef_pkg::CH_CARET;
                        tlen = tlen + 3'd1;
                        tail[tlen] = tlnef_pkg::CH_QMARK;
                        tlen = tlen + 3'd1;
                    end
                    else
                    begin
                        tail[tlen] = {1'b0, low7};
                        tlen = tlen + 3'd1;
                    end
                end
                if (in_last && mark_ends_reg)
                begin
                    tail[tlen] = tlnef_pkg::CH_DOLLAR;
                    tlen = tlen + 3'd1;
                end
            end
        end

        if (in_last)
        begin
            blank_seen_next = 1'b0;
            line_start_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            blank_seen_reg <= 1'b0;
            count_reg      <= '0;
            bcd_reg        <= '0;
        end
        else if (accept)
        begin
            line_start_reg <= line_start_next;
            blank_seen_reg <= blank_seen_next;
            count_reg      <= count_next;
            bcd_reg        <= bcd_next;
        end
    end

    assign q_push         = accept && !drop;
    assign q_job.has_num  = num;
    assign q_job.bcd      = bcd_next;
    assign q_job.tail     = tail;
    assign q_job.tail_len = tlen;

endmodule

FILE: src/tlnef_queue.sv
module tlnef_queue #(
    parameter int DEPTH = tlnef_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tlnef_pkg::job_t push_job,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output tlnef_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlnef_pkg::job_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: src/tlnef_back.sv
module tlnef_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  tlnef_pkg::job_t head_job,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [3:0] k_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    logic [3:0] ndig;
    logic [3:0] numlen;
    logic [3:0] num_bytes;
    logic [4:0] total;
    logic [3:0] dpos;
    logic [3:0] toff;
    logic [7:0] byte_sel;
    logic       is_last;
    logic       load;

    // Significant digits of the line number, at least one
    always_comb
    begin
        ndig = 4'd1;
        for (int i = 1; i < tlnef_pkg::DEC_DIGITS; i++)
        begin
            if (head_job.bcd[i] != 4'd0)
                ndig = 4'(i + 1);
        end
    end

    always_comb
    begin
        numlen    = (ndig > 4'(tlnef_pkg::PAD_WIDTH)) ? ndig : 4'(tlnef_pkg::PAD_WIDTH);
        num_bytes = head_job.has_num ? numlen + 4'd1 : 4'd0;
        total     = {1'b0, num_bytes} + {2'b00, head_job.tail_len};
        dpos      = numlen - 4'd1 - k_reg;
        toff      = k_reg - num_bytes;
        if (k_reg < num_bytes)
        begin
            if (k_reg == numlen)
                byte_sel = tlnef_pkg::CH_TAB;
            else if (dpos >= ndig)
                byte_sel = tlnef_pkg::CH_SPACE;
            else
                byte_sel = {tlnef_pkg::CH_DIGIT_HI, head_job.bcd[dpos]};
        end
        else
            byte_sel = head_job.tail[toff[2:0]];
        is_last = ({1'b0, k_reg} + 5'd1 == total);
    end

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                k_reg <= is_last ? 4'd0 : k_reg + 4'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= byte_sel;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: src/text_line_numbering_escape_filter_unit.sv
// Text line numbering and escape filter. Each input transfer carries one byte
// (s_tdata) and a last-byte-of-file flag (s_tlast); the unit produces zero or
// more output bytes per input, with m_tlast set on the last byte caused by that
// input. Depending on the registers it numbers lines (every line or non-blank
// lines only, six places right-justified plus a tab), drops repeated blank lines,
// shows tabs as ^I, shows control and high bytes in ^X and M- notation, and marks
// line ends with '$'. The line number runs on across files and saturates at
// min(2^COUNT_WIDTH-1, 9999999999). Rate: the front end classifies one input per
// cycle while the queue is not full and hands it through a QUEUE_DEPTH-entry queue
// (two by default) to the back end, which emits one output byte per cycle while
// m_tready is high. Each kept input produces 1 to 16 bytes; a dropped blank line
// produces no output. The front end can take new inputs while the back end is
// still emitting earlier ones. No reset sweep; s_tready is high from reset on, so
// a byte can be taken as soon as reset is released.
module text_line_numbering_escape_filter_unit #(
    parameter int COUNT_WIDTH = tlnef_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = tlnef_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // file_end
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast    // run_last
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    tlnef_pkg::job_t push_job;
    tlnef_pkg::job_t head_job;

    // Front: config registers, line state, classification of each byte
    tlnef_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Queue: hold classified jobs so each side stalls on its own
    tlnef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    // Back: expand the head job into prefix and byte expansion, one per cycle while m_tready is high
    tlnef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // A job leaves the queue only when it is present
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // An empty queue always takes input
    assert property (@(posedge clk) disable iff (!rst_n) !q_valid |-> s_tready)
        else $error("input stalled with empty queue");

    // Retiring a job presents its final byte on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> (m_tvalid && m_tlast))
        else $error("job retired without final output byte");

endmodule
